>>> hw/rtl/dses_pkg.sv
// Package with the types, codes and sine table of the drive state enabler.
package dses_pkg;

	localparam logic [3:0] ST_NOT_READY = 4'd0;
	localparam logic [3:0] ST_DISABLED = 4'd1;
	localparam logic [3:0] ST_READY = 4'd2;
	localparam logic [3:0] ST_SWITCHED_ON = 4'd3;
	localparam logic [3:0] ST_ENABLED = 4'd4;
	localparam logic [3:0] ST_QUICK_STOP = 4'd5;
	localparam logic [3:0] ST_FAULT_REACT = 4'd6;
	localparam logic [3:0] ST_FAULT = 4'd7;
	localparam logic [3:0] ST_UNKNOWN = 4'd8;

	localparam logic [7:0] CW_SHUTDOWN = 8'h06;
	localparam logic [7:0] CW_SWITCH_ON = 8'h07;
	localparam logic [7:0] CW_ENABLE = 8'h0F;
	localparam logic [7:0] CW_RESET = 8'h80;

	localparam logic [1:0] REG_AMPLITUDE = 2'd0;
	localparam logic [1:0] REG_PHASE_INC = 2'd1;
	localparam logic [1:0] REG_RUN_MODE = 2'd2;

	localparam int SINE_FRAC = 18;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [1:0] out_axis;
		logic control_valid;
		logic [7:0] control_word;
		logic target_valid;
		logic [31:0] target_position;
		logic mode_valid;
		logic [7:0] mode_of_operation;
		logic [3:0] decoded_state;
		logic last_result;
	} result_t;

	function automatic logic [3:0] decode_status(input logic [15:0] sw);
		logic [7:0] a;
		logic [7:0] b;
		a = sw[7:0] & 8'h4F;
		b = sw[7:0] & 8'h6F;
		if (a == 8'h00) return ST_NOT_READY;
		if (a == 8'h08) return ST_FAULT;
		if (a == 8'h40) return ST_DISABLED;
		if (b == 8'h27) return ST_ENABLED;
		if (b == 8'h23) return ST_SWITCHED_ON;
		if (b == 8'h21) return ST_READY;
		if (b == 8'h07) return ST_QUICK_STOP;
		if (a == 8'h0F) return ST_FAULT_REACT;
		return ST_UNKNOWN;
	endfunction

	// Quarter-wave entry, evaluated as a constant table at elaboration.
	function automatic logic [18:0] quarter_sine(input int idx, input int tbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] v;
		x = (HALF_PI_Q30 * 64'(idx)) >> tbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		for (int k = 1; k <= 12; k++) begin
			term = (term * x2) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = 0;
		v = (64'(sum) + 64'd2048) >> 12;
		if (v > 64'd262144) v = 64'd262144;
		return v[18:0];
	endfunction

endpackage

>>> hw/rtl/dses_sine.sv
// Sine lookup and scaled offset for one trajectory target, two stages.
module dses_sine #(
	parameter int TBITS = 10
) (
	input logic clk,
	input logic [31:0] phase,
	input logic [23:0] amplitude,
	input logic [31:0] origin,
	output logic [31:0] target
);
	import dses_pkg::*;

	localparam int QLEN = 1 << TBITS;
	logic [18:0] rom [QLEN + 1];
	logic [TBITS:0] addr;
	logic [18:0] mag_s1;
	logic neg_s1;
	logic [23:0] amp_s1;
	logic [31:0] org_s1;
	logic [42:0] prod;
	logic [31:0] off;

	for (genvar i = 0; i <= QLEN; i++) begin : g_rom
		assign rom[i] = quarter_sine(i, TBITS);
	end

	always_comb begin
		if (phase[30]) addr = (TBITS + 1)'(QLEN) - {1'b0, phase[29 -: TBITS]};
		else addr = {1'b0, phase[29 -: TBITS]};
	end

	always_ff @(posedge clk) begin
		mag_s1 <= rom[addr];
		neg_s1 <= phase[31];
		amp_s1 <= amplitude;
		org_s1 <= origin;
	end

	assign prod = amp_s1 * mag_s1;
	assign off = 32'(prod[42:SINE_FRAC]);

	always_ff @(posedge clk) begin
		target <= neg_s1 ? org_s1 - off : org_s1 + off;
	end
endmodule

>>> hw/rtl/drive_state_enabler_sine_traj.sv
// Top level of the drive state enabler with sine trajectory.
// An item carrying an axis sample is accepted in idle; the axis state and
// origin are read from the per-axis memory, updated and written back, and
// the axis result is offered. When the last item of a bus cycle finds every
// axis running, a trajectory pass follows that reads each axis entry in turn
// through a two-stage sine unit and offers its target, waiting while the output
// side stalls. Items with bus_ok low are dropped. After reset a clearing pass
// zeroes the memory before the first item is accepted.
module drive_state_enabler_sine_traj #(
	parameter int AXIS_COUNT = 4,
	parameter int SINE_TABLE_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// axis[1:0], status[17:2], actual_position[49:18], bus_ok[50], pad
	input logic [55:0] s_tdata,
	input logic s_tlast, // cycle_last
	output logic m_tvalid,
	input logic m_tready,
	// out_axis, control_valid, control_word, target_valid, target_position,
	// mode_valid, mode_of_operation, decoded_state, pad, from bit 0 up
	output logic [63:0] m_tdata,
	output logic m_tlast, // last_result
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import dses_pkg::*;

	localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_UPD = 7'b0000100,
		S_OUT = 7'b0001000,
		S_TREAD = 7'b0010000,
		S_TCALC = 7'b0100000,
		S_TOUT = 7'b1000000
	} fsm_t;

	fsm_t state_q;
	logic [23:0] amp_q;
	logic [31:0] inc_q;
	logic [7:0] mode_q;
	logic signed [7:0] run_q;
	logic [1:0] tcnt_q;

	// Per-axis memory entry: state, origin, phase.
	logic [67:0] mem [AXIS_COUNT];
	logic [67:0] rd_q;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr_q;
	logic [67:0] wdata_q;
	logic we_q;
	logic [AW-1:0] cur_q;
	logic [AW:0] tj_q;
	logic [1:0] in_axis_q;
	logic [15:0] sw_q;
	logic [31:0] pos_q;
	logic last_q;
	logic axis_in_q;
	result_t res_q;
	logic [31:0] tgt;
	logic [3:0] st;
	logic run_ok;
	logic [2:0] rwin;
	logic signed [7:0] run_nxt;
	logic run_ok_nxt;
	logic we_nxt;
	result_t axis_res;
	result_t traj_res;
	logic [67:0] axis_wdata;

	assign pready = 1'b1;
	always_comb begin
		case (paddr[3:2])
			REG_AMPLITUDE: prdata = {8'd0, amp_q};
			REG_PHASE_INC: prdata = inc_q;
			REG_RUN_MODE: prdata = {24'd0, mode_q};
			default: prdata = 32'd0;
		endcase
	end

	assign rwin = 3'(AXIS_COUNT);
	assign run_ok = (run_q >= 0) && ({1'b0, run_q[6:0]} >= 8'(AXIS_COUNT));
	assign s_tready = (state_q == S_IDLE) && !we_q;
	assign m_tvalid = (state_q == S_OUT) || (state_q == S_TOUT);
	assign m_tlast = res_q.last_result;
	assign m_tdata = {3'd0, res_q.decoded_state, res_q.mode_of_operation, res_q.mode_valid,
		res_q.target_position, res_q.target_valid, res_q.control_word,
		res_q.control_valid, res_q.out_axis};
	assign st = decode_status(sw_q);

	always_comb begin
		if (state_q == S_IDLE) raddr = AW'(s_tdata[1:0]);
		else if (state_q == S_READ) raddr = cur_q;
		else raddr = tj_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (we_q) mem[waddr_q] <= wdata_q;
		rd_q <= mem[raddr];
	end

	dses_sine #(.TBITS(SINE_TABLE_BITS)) u_sine (
		.clk(clk),
		.phase(rd_q[31:0]),
		.amplitude(amp_q),
		.origin(rd_q[63:32]),
		.target(tgt)
	);

	always_comb begin
		run_nxt = run_q;
		axis_res = '0;
		axis_res.out_axis = in_axis_q;
		axis_res.decoded_state = st;
		axis_wdata = {st, rd_q[63:0]};
		if (st != rd_q[67:64]) begin
			unique case (st)
				ST_DISABLED: begin
					axis_res.control_valid = 1'b1;
					axis_res.control_word = CW_SHUTDOWN;
				end
				ST_READY: begin
					axis_res.control_valid = 1'b1;
					axis_res.control_word = CW_SWITCH_ON;
				end
				ST_SWITCHED_ON: begin
					axis_res.control_valid = 1'b1;
					axis_res.control_word = CW_ENABLE;
				end
				ST_ENABLED: begin
					axis_wdata = {st, pos_q, rd_q[31:0]};
					axis_res.target_valid = 1'b1;
					axis_res.target_position = pos_q;
					if (run_q != 8'sd127) run_nxt = run_q + 8'sd1;
				end
				ST_FAULT: begin
					axis_res.control_valid = 1'b1;
					axis_res.control_word = CW_RESET;
					if (run_q != -8'sd128) run_nxt = run_q - 8'sd1;
				end
				default: ;
			endcase
		end
		run_ok_nxt = (run_nxt >= 0) && ({1'b0, run_nxt[6:0]} >= 8'(AXIS_COUNT));
		// A trajectory pass that follows takes the last mark off the axis result.
		axis_res.last_result = !(last_q && run_ok_nxt);
	end

	always_comb begin
		traj_res = '0;
		traj_res.out_axis = 2'(tj_q);
		traj_res.target_valid = 1'b1;
		traj_res.target_position = tgt;
		traj_res.mode_valid = 1'b1;
		traj_res.mode_of_operation = mode_q;
		traj_res.decoded_state = rd_q[67:64];
		traj_res.last_result = (32'(tj_q) + 1 == AXIS_COUNT);
	end

	assign we_nxt = ((state_q == S_IDLE) && we_q && (32'(waddr_q) + 1 < AXIS_COUNT)) ||
		((state_q == S_UPD) && axis_in_q) ||
		((state_q == S_TCALC) && (tcnt_q == 2'd2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			amp_q <= 24'd262144;
			inc_q <= 32'd429497;
			mode_q <= 8'd8;
			run_q <= '0;
			tcnt_q <= '0;
			we_q <= 1'b1;
			waddr_q <= '0;
			wdata_q <= '0;
			tj_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_AMPLITUDE: amp_q <= pwdata[23:0];
					REG_PHASE_INC: inc_q <= pwdata;
					REG_RUN_MODE: mode_q <= pwdata[7:0];
					default: ;
				endcase
			end
			we_q <= we_nxt;
			unique case (state_q)
				S_IDLE: begin
					// Clearing pass after reset fills the memory.
					if (we_q && (32'(waddr_q) + 1 < AXIS_COUNT)) begin
						waddr_q <= waddr_q + 1'b1;
					end else if (s_tvalid && s_tready && s_tdata[50]) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_UPD;
				S_UPD: begin
					if (axis_in_q) begin
						res_q <= axis_res;
						wdata_q <= axis_wdata;
						waddr_q <= cur_q;
						run_q <= run_nxt;
						state_q <= S_OUT;
					end else if (last_q && run_ok) begin
						tj_q <= '0;
						state_q <= S_TREAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						if (last_q && run_ok) begin
							tj_q <= '0;
							state_q <= S_TREAD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_TREAD: begin
					tcnt_q <= '0;
					if (!we_q) state_q <= S_TCALC;
				end
				S_TCALC: begin
					tcnt_q <= tcnt_q + 2'd1;
					if (tcnt_q == 2'd2) begin
						res_q <= traj_res;
						wdata_q <= {rd_q[67:32], rd_q[31:0] + inc_q};
						waddr_q <= tj_q[AW-1:0];
						state_q <= S_TOUT;
					end
				end
				S_TOUT: begin
					if (m_tready) begin
						if (32'(tj_q) + 1 == AXIS_COUNT) state_q <= S_IDLE;
						else begin
							tj_q <= tj_q + 1'b1;
							state_q <= S_TREAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid && s_tready) begin
			in_axis_q <= s_tdata[1:0];
			cur_q <= AW'(s_tdata[1:0]);
			axis_in_q <= ({1'b0, s_tdata[1:0]} < rwin) || (AXIS_COUNT > 4);
			sw_q <= s_tdata[17:2];
			pos_q <= s_tdata[49:18];
			last_q <= s_tlast;
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOUT && !m_tready) |=> state_q == S_TOUT)
		else $error("trajectory item dropped");
	a_no_write_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TREAD) |=> !(we_q && state_q == S_TCALC && tcnt_q == 2'd0))
		else $error("stale memory read");
`endif
endmodule
